[hdl/rwd_pkg.sv]
// Shared types, codes and constants of the RGB 3x3 denoise filter.
package rwd_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int CFG_W = 12;
  localparam int POS_W = 11;
  localparam int SZ_W  = 14;

  localparam logic [1:0] MODE_GAUSS  = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;
  localparam logic [1:0] MODE_MEAN   = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // x / 9 == (x * 7282) >> 16 for x below 2296
  localparam logic [12:0] MEAN_RECIP = 13'd7282;
  localparam int          MEAN_SHIFT = 16;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;

  typedef logic [7:0]       chan_t;
  typedef logic [23:0]      pix_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic ea;
    logic filt;
    logic eb;
    logic ec;
    pos_t row;
    pos_t col;
    pix_t pix;
    pix_t newer;
    pix_t center;
  } meta_t;

  typedef struct packed {
    pix_t pix;
    pos_t row;
    pos_t col;
    logic last;
  } result_t;

endpackage

[hdl/rwd_ram.sv]
// Generic single write port, single read port RAM with registered read.
module rwd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[hdl/rwd_col_cell.sv]
// One window column cell: three pixels, shifted on to the next cell.
module rwd_col_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  rwd_pkg::pix_t top_i,
  input  rwd_pkg::pix_t mid_i,
  input  rwd_pkg::pix_t bot_i,
  output rwd_pkg::pix_t top_o,
  output rwd_pkg::pix_t mid_o,
  output rwd_pkg::pix_t bot_o
);
  import rwd_pkg::*;

  pix_t top_r, mid_r, bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      mid_r <= '0;
      bot_r <= '0;
    end else if (en) begin
      top_r <= top_i;
      mid_r <= mid_i;
      bot_r <= bot_i;
    end
  end

  assign top_o = top_r;
  assign mid_o = mid_r;
  assign bot_o = bot_r;

endmodule

[hdl/rwd_chan_filt.sv]
// Two-stage filter of one color channel over the 3x3 window.
module rwd_chan_filt (
  input  logic          clk,
  input  logic [1:0]    mode,
  input  rwd_pkg::chan_t v_i [9],
  output rwd_pkg::chan_t res_o
);
  import rwd_pkg::*;

  function automatic chan_t min2(input chan_t a, input chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(input chan_t a, input chan_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // stage 1: per column sort and weighted sums
  chan_t      lo_r [3], md_r [3], hi_r [3];
  logic [9:0] cs_r [3], ss_r [3];
  chan_t      ctr1_r;
  // stage 2: partial median and totals
  chan_t       mxlo_r, mdmd_r, mnhi_r, ctr2_r;
  logic [11:0] g_r, s_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      lo_r[j] <= min2(min2(v_i[j], v_i[3+j]), v_i[6+j]);
      hi_r[j] <= max2(max2(v_i[j], v_i[3+j]), v_i[6+j]);
      md_r[j] <= med3(v_i[j], v_i[3+j], v_i[6+j]);
      cs_r[j] <= 10'(v_i[j]) + {1'b0, v_i[3+j], 1'b0} + 10'(v_i[6+j]);
      ss_r[j] <= 10'(v_i[j]) + 10'(v_i[3+j]) + 10'(v_i[6+j]);
    end
    ctr1_r <= v_i[4];
    mxlo_r <= max2(max2(lo_r[0], lo_r[1]), lo_r[2]);
    mnhi_r <= min2(min2(hi_r[0], hi_r[1]), hi_r[2]);
    mdmd_r <= med3(md_r[0], md_r[1], md_r[2]);
    g_r    <= 12'(cs_r[0]) + {1'b0, cs_r[1], 1'b0} + 12'(cs_r[2]);
    s_r    <= 12'(ss_r[0]) + 12'(ss_r[1]) + 12'(ss_r[2]);
    ctr2_r <= ctr1_r;
  end

  logic [24:0] mean_prod;
  assign mean_prod = 25'(s_r) * 25'(MEAN_RECIP);

  always_comb begin
    case (mode)
      MODE_GAUSS:  res_o = g_r[11:4];
      MODE_MEDIAN: res_o = med3(mxlo_r, mdmd_r, mnhi_r);
      MODE_MEAN:   res_o = mean_prod[MEAN_SHIFT+7:MEAN_SHIFT];
      default:     res_o = ctr2_r;
    endcase
  end

endmodule

[hdl/rgb_window3x3_denoise_filter.sv]
// Top level of the streaming RGB 3x3 denoise filter.
//
// Pixels enter in raster order on the in_ channel (valid/stall); a pixel is
// taken at a clock edge where in_valid is high and in_stall is low. Results
// leave on the out_ channel, each with its own row and column; out_run_last
// marks the final result caused by one input pixel. Interior pixels are
// filtered per channel (Gaussian, median or mean, set by cfg register 0);
// border pixels pass through. Frame size sits in cfg registers 1 and 2.
// A taken pixel moves through stages s1 to s4, then its first result is
// written to the result queue and shows on out_valid. Throughput is one
// pixel per cycle while in_stall is low, set by the single read port of
// the line store and the shift of the window cell chain; row ends give two
// results and the last row up to three per pixel, there the rate follows
// the output at one result per cycle. A 16-entry result queue sits at the
// output; in_stall rises when it could not hold the results of the pixels
// in flight plus one more, so a stalled receiver stops input; none is lost.
// Reset clears position counters, window and queue; the line store needs no
// clearing pass, its stale entries only feed border results.
module rgb_window3x3_denoise_filter #(
  parameter int MAX_WIDTH  = rwd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rwd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_blue_in,
  input  logic [7:0]               in_green_in,
  input  logic [7:0]               in_red_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_blue_out,
  output logic [7:0]               out_green_out,
  output logic [7:0]               out_red_out,
  output logic [rwd_pkg::POS_W-1:0] out_row,
  output logic [rwd_pkg::POS_W-1:0] out_column,
  output logic                     out_run_last,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [rwd_pkg::CFG_W-1:0] cfg_wdata
);
  import rwd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // configuration
  logic [1:0]       mode_r;
  logic [CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_GAUSS;
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_wdata[1:0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  logic [SZ_W-1:0] w_cfg, h_cfg, w_eff, h_eff;
  assign w_cfg = SZ_W'(width_r);
  assign h_cfg = SZ_W'(height_r);
  assign w_eff = (w_cfg < SZ_W'(3)) ? SZ_W'(3) :
                 (w_cfg > SZ_W'(MAX_WIDTH)) ? SZ_W'(MAX_WIDTH) : w_cfg;
  assign h_eff = (h_cfg < SZ_W'(3)) ? SZ_W'(3) :
                 (h_cfg > SZ_W'(MAX_HEIGHT)) ? SZ_W'(MAX_HEIGHT) : h_cfg;

  // input stage: position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          in_acc, last_col, last_row;

  assign in_acc   = in_valid && !in_stall;
  assign last_col = SZ_W'(col_r) >= (w_eff - SZ_W'(1));
  assign last_row = SZ_W'(row_r) >= (h_eff - SZ_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // pipeline valid bits and per-item control
  logic          s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  meta_t         s1_r, s2_r, s3_r, s4_r, s1_nxt, s2_nxt, s3_nxt;
  logic [CW-1:0] s1_idx_r;

  always_comb begin
    s1_nxt        = '0;
    s1_nxt.ea     = (row_r != '0) && (col_r != '0);
    s1_nxt.filt   = (row_r > RW'(1)) && (col_r > CW'(1));
    s1_nxt.eb     = (row_r != '0) && last_col;
    s1_nxt.ec     = last_row;
    s1_nxt.row    = POS_W'(row_r);
    s1_nxt.col    = POS_W'(col_r);
    s1_nxt.pix    = {in_red_in, in_green_in, in_blue_in};
  end

  // line store: low half row r-1, high half row r-2
  logic [47:0] ls_rdata;
  pix_t        older, newer;
  assign older = ls_rdata[47:24];
  assign newer = ls_rdata[23:0];

  rwd_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_line_store (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_idx_r),
    .wdata ({newer, s1_r.pix}),
    .raddr (col_r),
    .rdata (ls_rdata)
  );

  // window: cell 2 holds the newest column
  pix_t cell_top [3], cell_mid [3], cell_bot [3];

  rwd_col_cell u_cell2 (
    .clk(clk), .rst_n(rst_n), .en(s1_v_r),
    .top_i(older), .mid_i(newer), .bot_i(s1_r.pix),
    .top_o(cell_top[2]), .mid_o(cell_mid[2]), .bot_o(cell_bot[2])
  );
  rwd_col_cell u_cell1 (
    .clk(clk), .rst_n(rst_n), .en(s1_v_r),
    .top_i(cell_top[2]), .mid_i(cell_mid[2]), .bot_i(cell_bot[2]),
    .top_o(cell_top[1]), .mid_o(cell_mid[1]), .bot_o(cell_bot[1])
  );
  rwd_col_cell u_cell0 (
    .clk(clk), .rst_n(rst_n), .en(s1_v_r),
    .top_i(cell_top[1]), .mid_i(cell_mid[1]), .bot_i(cell_bot[1]),
    .top_o(cell_top[0]), .mid_o(cell_mid[0]), .bot_o(cell_bot[0])
  );

  chan_t filt_res [3];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    chan_t win [9];
    for (genvar j = 0; j < 3; j++) begin : g_col
      assign win[j]   = cell_top[j][8*k +: 8];
      assign win[3+j] = cell_mid[j][8*k +: 8];
      assign win[6+j] = cell_bot[j][8*k +: 8];
    end
    rwd_chan_filt u_filt (
      .clk   (clk),
      .mode  (mode_r),
      .v_i   (win),
      .res_o (filt_res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_comb begin
    s2_nxt        = s1_r;
    s2_nxt.newer  = newer;
    s3_nxt        = s2_r;
    s3_nxt.center = cell_mid[1];
  end

  always_ff @(posedge clk) begin
    s1_r     <= s1_nxt;
    s1_idx_r <= col_r;
    s2_r     <= s2_nxt;
    s3_r     <= s3_nxt;
    s4_r     <= s3_r;
  end

  // result queue
  result_t res_a, res_b, res_c, slot [3];
  logic [1:0] n_push;
  logic       pop;

  always_comb begin
    res_a.pix  = s4_r.filt ? {filt_res[2], filt_res[1], filt_res[0]} : s4_r.center;
    res_a.row  = s4_r.row - POS_W'(1);
    res_a.col  = s4_r.col - POS_W'(1);
    res_a.last = !s4_r.eb && !s4_r.ec;
    res_b.pix  = s4_r.newer;
    res_b.row  = s4_r.row - POS_W'(1);
    res_b.col  = s4_r.col;
    res_b.last = !s4_r.ec;
    res_c.pix  = s4_r.pix;
    res_c.row  = s4_r.row;
    res_c.col  = s4_r.col;
    res_c.last = 1'b1;
    slot[0] = s4_r.ea ? res_a : (s4_r.eb ? res_b : res_c);
    slot[1] = (s4_r.ea && s4_r.eb) ? res_b : res_c;
    slot[2] = res_c;
    n_push  = s4_v_r ? (2'(s4_r.ea) + 2'(s4_r.eb) + 2'(s4_r.ec)) : 2'd0;
  end

  result_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;
  logic [2:0]           inflight;
  logic [FIFO_AW+1:0]   reserve;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;
  assign cnt_nxt   = cnt_r + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);

  // room for the queue plus three results for every pixel in flight and one more
  assign inflight = 3'(s1_v_r) + 3'(s2_v_r) + 3'(s3_v_r) + 3'(s4_v_r);
  assign reserve  = (FIFO_AW+2)'(cnt_r) + (FIFO_AW+2)'(inflight) * (FIFO_AW+2)'(3)
                    + (FIFO_AW+2)'(3);
  assign in_stall = reserve > (FIFO_AW+2)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_push) begin
        fifo_r[wr_ptr_r + FIFO_AW'(k)] <= slot[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(n_push);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  result_t head;
  assign head          = fifo_r[rd_ptr_r];
  assign out_blue_out  = head.pix[7:0];
  assign out_green_out = head.pix[15:8];
  assign out_red_out   = head.pix[23:16];
  assign out_row       = head.row;
  assign out_column    = head.col;
  assign out_run_last  = head.last;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_filt_needs_a: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && s4_r.filt |-> s4_r.ea)
    else $error("filtered result without emission");

  a_accept_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted pixel lost");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SZ_W'(col_r) < SZ_W'(MAX_WIDTH))
    else $error("column counter out of range");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench of the RGB 3x3 denoise filter: frames in, filtered pixels checked.
`timescale 1ns / 100ps

module testbench;
  import rwd_pkg::*;

  localparam int LINE_MAX = 2048;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  class frame_scoreboard;
    logic [1:0]       mode;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    int               row_n;
    int               col_n;
    pix_t             window [9];
    logic [47:0]      line_mem [LINE_MAX];
    result_t          expected_q [$];
    int               errors;

    function new();
      mode = MODE_GAUSS;
      width = CFG_W'(640);
      height = CFG_W'(480);
      row_n = 0;
      col_n = 0;
      errors = 0;
      foreach (window[i]) window[i] = '0;
      foreach (line_mem[i]) line_mem[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_MODE) mode = val[1:0];
      else if (idx == REG_WIDTH) width = val;
      else if (idx == REG_HEIGHT) height = val;
    endfunction

    function int clamp(int v, int hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function pix_t filtered();
      pix_t res;
      int v [9];
      int sum, gsum, t, j;
      int wt [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
      for (int sh = 0; sh < 24; sh += 8) begin
        sum = 0;
        gsum = 0;
        for (int i = 0; i < 9; i++) begin
          v[i] = int'(window[i][sh +: 8]);
          sum += v[i];
          gsum += v[i] * wt[i];
        end
        case (mode)
          MODE_GAUSS: t = gsum / 16;
          MODE_MEAN: t = sum / 9;
          MODE_MEDIAN: begin
            for (int i = 1; i < 9; i++) begin
              t = v[i];
              j = i - 1;
              while (j >= 0 && v[j] > t) begin
                v[j + 1] = v[j];
                j--;
              end
              v[j + 1] = t;
            end
            t = v[4];
          end
          default: t = v[4];  // unused mode passes the center through
        endcase
        res[sh +: 8] = t[7:0];
      end
      return res;
    endfunction

    function void note_pixel(pix_t p);
      int w, h, r, c, idx, n;
      bit lc, lr;
      logic [47:0] entry;
      result_t res [3];
      w = clamp(int'(width), LINE_MAX);
      h = clamp(int'(height), LINE_MAX);
      r = row_n;
      c = col_n;
      lc = c >= w - 1;
      lr = r >= h - 1;
      idx = (c < LINE_MAX) ? c : LINE_MAX - 1;
      entry = line_mem[idx];
      n = 0;
      for (int i = 0; i < 3; i++) begin
        window[i*3] = window[i*3+1];
        window[i*3+1] = window[i*3+2];
      end
      window[2] = entry[47:24];
      window[5] = entry[23:0];
      window[8] = p;
      line_mem[idx] = {entry[23:0], p};
      if (r >= 1 && c >= 1) begin
        res[n] = '{pix: (r >= 2 && c >= 2) ? filtered() : window[4],
                   row: pos_t'(r - 1), col: pos_t'(c - 1), last: 1'b0};
        n++;
      end
      if (r >= 1 && lc) begin
        res[n] = '{pix: window[5], row: pos_t'(r - 1), col: pos_t'(c), last: 1'b0};
        n++;
      end
      if (lr) begin
        res[n] = '{pix: p, row: pos_t'(r), col: pos_t'(c), last: 1'b0};
        n++;
      end
      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
      if (lc) begin
        col_n = 0;
        row_n = lr ? 0 : r + 1;
      end else begin
        col_n = c + 1;
      end
    endfunction

    function void check_result(result_t act);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d pix %h", $time, act.row, act.col,
                 act.pix);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (act.pix[7:0] !== exp_r.pix[7:0]) begin
        $display("%0t: blue expected %0d actual %0d", $time, exp_r.pix[7:0], act.pix[7:0]);
        errors++;
      end
      if (act.pix[15:8] !== exp_r.pix[15:8]) begin
        $display("%0t: green expected %0d actual %0d", $time, exp_r.pix[15:8], act.pix[15:8]);
        errors++;
      end
      if (act.pix[23:16] !== exp_r.pix[23:16]) begin
        $display("%0t: red expected %0d actual %0d", $time, exp_r.pix[23:16],
                 act.pix[23:16]);
        errors++;
      end
      if (act.row !== exp_r.row) begin
        $display("%0t: row expected %0d actual %0d", $time, exp_r.row, act.row);
        errors++;
      end
      if (act.col !== exp_r.col) begin
        $display("%0t: column expected %0d actual %0d", $time, exp_r.col, act.col);
        errors++;
      end
      if (act.last !== exp_r.last) begin
        $display("%0t: run_last expected %0b actual %0b", $time, exp_r.last, act.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_blue_in;
  logic [7:0]       in_green_in;
  logic [7:0]       in_red_in;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_blue_out;
  logic [7:0]       out_green_out;
  logic [7:0]       out_red_out;
  pos_t             out_row;
  pos_t             out_column;
  logic             out_run_last;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  frame_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int idle_cycles = 0;
  int pixels_sent;

  rgb_window3x3_denoise_filter i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{pix: {out_red_out, out_green_out, out_blue_out}, row: out_row,
                        col: out_column, last: out_run_last});
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall))) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    {in_red_in, in_green_in, in_blue_in} <= p;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  function automatic logic [7:0] rand_chan();
    int k;
    k = $urandom_range(7);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // frames always start at row 0 with the block drained, so the line store
  // is filled before any interior window reads it
  task automatic setup_frame(logic [1:0] mode, int w, int h, int idle_mode);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (sb.expected_q.size() == 0);
    repeat (8) @(posedge clk);
    write_reg(REG_MODE, CFG_W'(mode));
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    case (idle_mode % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 57; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 57; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  task automatic random_frame(logic [1:0] mode, int w, int h, int idle_mode);
    int pw, ph;
    pw = (w < 3) ? 3 : (w > LINE_MAX ? LINE_MAX : w);
    ph = (h < 3) ? 3 : (h > LINE_MAX ? LINE_MAX : h);
    setup_frame(mode, w, h, idle_mode);
    for (int i = 0; i < pw * ph; i++)
      send_pixel({rand_chan(), rand_chan(), rand_chan()});
  endtask

  initial begin
    int frame_n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_blue_in = '0;
    in_green_in = '0;
    in_red_in = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    pixels_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // checkerboard of extremes through Gaussian
    setup_frame(MODE_GAUSS, 3, 3, 0);
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? 24'hffffff : 24'h000000);
    // all-max window through mean: largest sum
    setup_frame(MODE_MEAN, 3, 3, 1);
    for (int i = 0; i < 9; i++) send_pixel(24'hffffff);
    // undersized frame clamps to 3x3; unused mode passes center through
    setup_frame(2'd3, 0, 2, 2);
    for (int i = 0; i < 9; i++) send_pixel({8'(i * 29), 8'hff - 8'(i * 31), 8'(i * 7)});
    // median on mixed extremes, under a long receiver hold-off that fills the block
    hold_req++;
    random_frame(MODE_MEDIAN, 8, 6, 3);

    frame_n = 0;
    while (pixels_sent < 150) begin
      random_frame(2'($urandom_range(3)), $urandom_range(3, 9), $urandom_range(3, 6),
                   frame_n);
      frame_n++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (sb.expected_q.size() == 0);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rwd_pkg.sv
hdl/rwd_ram.sv
hdl/rwd_col_cell.sv
hdl/rwd_chan_filt.sv
hdl/rgb_window3x3_denoise_filter.sv
tb/sv/testbench.sv
